// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Assert an implication on every rising clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error(msg);
// Assert a next-cycle implication outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error(msg);
`endif

// ----- design/lnme_pkg.sv -----
// Package: constants and types of the landmark error block.
package lnme_pkg;
	localparam int MAX_POINTS_DEF = 68;
	localparam int MAX_BATCH_DEF  = 1024;
	localparam int LEFT_FIRST  = 36;
	localparam int RIGHT_FIRST = 42;
	localparam int EYE_END     = 48;
	localparam int MIN_POINTS  = 48;
	localparam int EYE_POINTS  = 6;

	// item handed from front to back
	typedef struct packed {
		logic signed [16:0] dx;
		logic signed [16:0] dy;
		logic signed [15:0] tx;
		logic signed [15:0] ty;
		logic        left;
		logic        right;
		logic        last;
		logic        final_flag;
		logic [6:0]  count;
	} lnme_cmd_t;

	typedef enum logic [2:0] {
		BK_IDLE, BK_DSQ, BK_ESQ, BK_DIV, BK_MEAN, BK_OUT
	} lnme_bstate_t;
endpackage

// ----- design/lnme_if.sv -----
// Interfaces: input and result channels.
interface lnme_in_if;
	logic               valid;
	logic               ready;
	logic signed [15:0] pred_x;
	logic signed [15:0] pred_y;
	logic signed [15:0] truth_x;
	logic signed [15:0] truth_y;
	logic               final_sample;
	modport source (output valid, pred_x, pred_y, truth_x, truth_y, final_sample,
		input ready);
	modport sink (input valid, pred_x, pred_y, truth_x, truth_y, final_sample,
		output ready);
endinterface

interface lnme_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] sample_error;
	logic [31:0] batch_mean;
	logic        batch_done;
	logic        eye_zero;
	logic        saturated;
	modport source (output valid, sample_error, batch_mean, batch_done, eye_zero,
		saturated, input ready);
	modport sink (input valid, sample_error, batch_mean, batch_done, eye_zero,
		saturated, output ready);
endinterface

// ----- design/lnme_front.sv -----
// Front: accepts landmarks, tracks the index and classifies eye points.
module lnme_front import lnme_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_we,
	input  logic [6:0]       cfg_data,
	lnme_in_if.sink          in_ch,
	output logic             q_push,
	input  logic             q_full,
	output lnme_cmd_t        q_data
);
	logic [6:0] count_q;
	logic [6:0] idx_q;
	logic [6:0] eff;

	// clamp the landmark count
	always_comb begin
		eff = count_q;
		if (count_q < 7'(MIN_POINTS)) eff = 7'(MIN_POINTS);
		if (count_q > 7'(MAX_POINTS)) eff = 7'(MAX_POINTS);
	end

	assign in_ch.ready = !q_full;
	assign q_push = in_ch.valid && !q_full;

	// classify the item
	always_comb begin
		q_data.dx = 17'(in_ch.pred_x) - 17'(in_ch.truth_x);
		q_data.dy = 17'(in_ch.pred_y) - 17'(in_ch.truth_y);
		q_data.tx = in_ch.truth_x;
		q_data.ty = in_ch.truth_y;
		q_data.left  = idx_q >= 7'(LEFT_FIRST) && idx_q < 7'(RIGHT_FIRST);
		q_data.right = idx_q >= 7'(RIGHT_FIRST) && idx_q < 7'(EYE_END);
		q_data.last  = {1'b0, idx_q} + 8'd1 >= {1'b0, eff};
		q_data.final_flag = in_ch.final_sample;
		q_data.count = eff;
	end

	// hold the count register, advance the index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 7'd68;
			idx_q <= '0;
		end else begin
			if (cfg_we) count_q <= cfg_data;
			if (q_push) idx_q <= q_data.last ? 7'd0 : idx_q + 7'd1;
		end
	end
endmodule

// ----- design/lnme_fifo.sv -----
// Short queue between front and back.
module lnme_fifo import lnme_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  lnme_cmd_t wdata,
	output logic      full,
	input  logic      pop,
	output logic      empty,
	output lnme_cmd_t rdata
);
	lnme_cmd_t mem_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full = cnt_q == 2'd2;
	assign empty = cnt_q == 2'd0;
	assign rdata = mem_q[rp_q];

	// store on push
	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= wdata;
	end

	// advance pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end
endmodule

// ----- design/lnme_back.sv -----
// Back: distance, centroid sums, division and batch mean.
module lnme_back import lnme_pkg::*; #(
	parameter int MAX_BATCH = MAX_BATCH_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  lnme_cmd_t q_data,
	output logic      q_pop,
	lnme_out_if.source out_ch
);
	lnme_bstate_t st_q, st_d;
	lnme_cmd_t    c_q;
	logic [39:0]  rad_q;
	logic [19:0]  root_q;
	logic [21:0]  rem_q;
	logic [5:0]   cnt_q;
	logic [31:0]  dsum_q;
	logic signed [18:0] lx_q, ly_q, rx_q, ry_q;
	logic [10:0]  tally_q;
	logic [47:0]  total_q;
	logic [63:0]  num_q;
	logic [63:0]  div_q;
	logic [63:0]  quo_q;
	logic [31:0]  err_q;
	logic         ez_q, sat_q, done_q;
	logic [31:0]  mean_q;
	logic signed [19:0] ex, ey;
	logic [21:0]  rt_try;
	logic [23:0]  rem_sh;
	logic [63:0]  sub;
	logic [47:0]  tsum;
	logic [10:0]  tnext;

	// one restoring sqrt step: two radicand bits in, one root bit out (20 steps)
	assign rem_sh = {rem_q, rad_q[39:38]};
	assign rt_try = {root_q, 2'b01};
	assign sub = num_q - div_q;
	assign ex = 20'(lx_q) - 20'(rx_q);
	assign ey = 20'(ly_q) - 20'(ry_q);
	assign tsum = total_q + 48'(err_q);
	assign tnext = tally_q + 11'd1;

	assign q_pop = st_q == BK_IDLE && !q_empty;
	assign out_ch.valid = st_q == BK_OUT;
	assign out_ch.sample_error = err_q;
	assign out_ch.batch_mean = mean_q;
	assign out_ch.batch_done = done_q;
	assign out_ch.eye_zero = ez_q;
	assign out_ch.saturated = sat_q;

	// next state
	always_comb begin
		st_d = st_q;
		case (st_q)
			BK_IDLE: if (!q_empty) st_d = BK_DSQ;
			BK_DSQ:  if (cnt_q == 6'd20) st_d = c_q.last ? BK_ESQ : BK_IDLE;
			BK_ESQ:  if (cnt_q == 6'd20) st_d = BK_DIV;
			BK_DIV:  if (cnt_q == 6'd34) st_d = BK_MEAN;
			BK_MEAN: if (cnt_q == 6'd38 || (cnt_q != 6'd0 && !done_q)) st_d = BK_OUT;
			BK_OUT:  if (out_ch.ready) st_d = BK_IDLE;
			default: st_d = BK_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) st_q <= BK_IDLE;
		else st_q <= st_d;
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dsum_q <= '0; lx_q <= '0; ly_q <= '0; rx_q <= '0; ry_q <= '0;
			tally_q <= '0; total_q <= '0;
			c_q <= '0; rad_q <= '0; root_q <= '0; rem_q <= '0; cnt_q <= '0;
			num_q <= '0; div_q <= '0; quo_q <= '0;
			err_q <= '0; ez_q <= 1'b0; sat_q <= 1'b0; done_q <= 1'b0; mean_q <= '0;
		end else begin
			case (st_q)
				BK_IDLE: if (!q_empty) begin
					c_q <= q_data;
					rad_q <= 40'($unsigned(34'(q_data.dx) * 34'(q_data.dx)))
						+ 40'($unsigned(34'(q_data.dy) * 34'(q_data.dy)));
					root_q <= '0; rem_q <= '0; cnt_q <= '0;
					if (q_data.left) begin
						lx_q <= lx_q + 19'(q_data.tx); ly_q <= ly_q + 19'(q_data.ty);
					end
					if (q_data.right) begin
						rx_q <= rx_q + 19'(q_data.tx); ry_q <= ry_q + 19'(q_data.ty);
					end
				end
				BK_DSQ, BK_ESQ: begin
					if (cnt_q == 6'd20) begin
						cnt_q <= '0;
						root_q <= '0; rem_q <= '0;
						if (st_q == BK_DSQ) begin
							if (33'(dsum_q) + 33'(root_q) > 33'hFFFFFFFF) dsum_q <= '1;
							else dsum_q <= dsum_q + 32'(root_q);
							rad_q <= 40'($unsigned(40'(ex) * 40'(ex)))
								+ 40'($unsigned(40'(ey) * 40'(ey)));
						end else begin
							num_q <= 64'({35'(dsum_q) * 35'd6, 16'd0});
							div_q <= 64'(32'(c_q.count) * 32'(root_q)) << 32;
							quo_q <= '0;
							ez_q <= root_q == '0;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
						rad_q <= rad_q << 2;
						if (rem_sh >= 24'(rt_try)) begin
							rem_q <= 22'(rem_sh - 24'(rt_try));
							root_q <= {root_q[18:0], 1'b1};
						end else begin
							rem_q <= 22'(rem_sh);
							root_q <= {root_q[18:0], 1'b0};
						end
					end
				end
				BK_DIV: begin
					// one quotient bit per cycle, 33 bits
					if (cnt_q == 6'd34) begin
						cnt_q <= '0;
						if (ez_q || quo_q[32]) begin
							err_q <= '1; sat_q <= 1'b1;
						end else begin
							err_q <= quo_q[31:0]; sat_q <= 1'b0;
						end
					end else begin
						cnt_q <= cnt_q + 6'd1;
						div_q <= div_q >> 1;
						if (num_q >= div_q && cnt_q != 6'd0) begin
							num_q <= sub; quo_q <= {quo_q[62:0], 1'b1};
						end else if (cnt_q != 6'd0) begin
							quo_q <= {quo_q[62:0], 1'b0};
						end
						if (cnt_q == 6'd0) div_q <= div_q >> 0;
					end
				end
				BK_MEAN: begin
					if (cnt_q == 6'd0) begin
						total_q <= tsum;
						tally_q <= tnext;
						done_q <= c_q.final_flag || tnext >= 11'(MAX_BATCH);
						num_q <= 64'(tsum);
						div_q <= 64'(tnext) << 36;
						quo_q <= '0;
						mean_q <= '0;
						cnt_q <= 6'd1;
						if (!(c_q.final_flag || tnext >= 11'(MAX_BATCH))) done_q <= 1'b0;
					end else if (cnt_q == 6'd38) begin
						mean_q <= quo_q[31:0] | {32{|quo_q[36:32]}};
						total_q <= '0; tally_q <= '0;
						cnt_q <= '0;
					end else begin
						cnt_q <= cnt_q + 6'd1;
						div_q <= div_q >> 1;
						if (num_q >= div_q) begin
							num_q <= sub; quo_q <= {quo_q[62:0], 1'b1};
						end else quo_q <= {quo_q[62:0], 1'b0};
					end
					if (cnt_q != 6'd0 && !done_q) cnt_q <= '0;
				end
				BK_OUT: begin
					dsum_q <= '0;
					if (out_ch.ready) begin
						lx_q <= '0; ly_q <= '0; rx_q <= '0; ry_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- design/landmark_normalized_mean_error_top.sv -----
// Top level: landmark normalized mean error.
//  channel | dir | handshake     | payload
//  in_ch   | in  | valid/ready   | pred_x pred_y truth_x truth_y final_sample
//  out_ch  | out | valid/ready   | sample_error batch_mean batch_done eye_zero saturated
//  cfg     | in  | cfg_we        | cfg_data (landmark_count)
// In the back end a landmark is popped, then runs a 20-step square root
// and its closing step.
// The last landmark adds an eye-distance root, a divide and a mean update (with a mean
// division when it closes the batch), then holds the result until out_ch.ready.
// Reset clears all sums; count resets to 68. The two-entry queue lets the front
// take items while the back works or waits on out_ch.ready.
module landmark_normalized_mean_error_top import lnme_pkg::*; #(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int MAX_BATCH  = MAX_BATCH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [6:0] cfg_data,
	lnme_in_if.sink    in_ch,
	lnme_out_if.source out_ch
);
	logic push, full, pop, empty;
	lnme_cmd_t wd, rd;

	lnme_front #(.MAX_POINTS(MAX_POINTS)) u_front (
		.clk, .arst_n, .cfg_we, .cfg_data, .in_ch,
		.q_push(push), .q_full(full), .q_data(wd));
	lnme_fifo u_fifo (.clk, .arst_n, .push, .wdata(wd), .full, .pop, .empty, .rdata(rd));
	lnme_back #(.MAX_BATCH(MAX_BATCH)) u_back (
		.clk, .arst_n, .q_empty(empty), .q_data(rd), .q_pop(pop), .out_ch);
endmodule

// ----- design/lnme_checker.sv -----
// Checker on the top level ports, with its bind.
`include "assert_macros.svh"
module lnme_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic batch_done,
	input logic eye_zero,
	input logic saturated,
	input logic [31:0] sample_error,
	input logic [31:0] batch_mean
);
	`CHK_IMPL(a_ez_sat, clk, arst_n, out_valid && eye_zero, saturated && sample_error == '1, "eye zero not saturated")
	`CHK_IMPL(a_mean0, clk, arst_n, out_valid && !batch_done, batch_mean == '0, "mean without done")
	`CHK_NEXT(a_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(sample_error), "result dropped")
endmodule

bind landmark_normalized_mean_error_top lnme_checker u_chk (
	.clk, .arst_n, .out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.batch_done(out_ch.batch_done), .eye_zero(out_ch.eye_zero),
	.saturated(out_ch.saturated), .sample_error(out_ch.sample_error),
	.batch_mean(out_ch.batch_mean));
